### hdl/wfms_pkg.sv
// Package with shared types and constants for the weighted feature match search block.
package wfms_pkg;

  localparam int unsigned MaxFrames = 4096;

  localparam int unsigned CostW = 48;
  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  localparam logic [2:0] FuncLoadFeat  = 3'd0;
  localparam logic [2:0] FuncLoadQuery = 3'd1;
  localparam logic [2:0] FuncLoadWght  = 3'd2;
  localparam logic [2:0] FuncLoadInv   = 3'd3;
  localparam logic [2:0] FuncSearch    = 3'd4;

  localparam logic [0:0] RegFrames = 1'b0;
  localparam logic [0:0] RegStride = 1'b1;

  typedef struct packed {
    logic [2:0]         func;
    logic [11:0]        frame_index;
    logic [5:0]         dim_index;
    logic signed [23:0] load_value;
    logic [11:0]        current_frame;
    logic [11:0]        exclude_span;
  } in_item_t;

  typedef struct packed {
    logic [11:0]      best_index;
    logic [CostW-1:0] best_cost;
    logic             found;
  } out_item_t;

endpackage

### hdl/weighted_feature_match_search.sv
// Top level of the weighted feature match search block with sequencer and shared MAC datapath.
// A load item never raises busy_o. A search scores each visited frame
// with one shared multiply unit; each dimension passes through store read, difference, four
// multiply steps and accumulate, each frame also passes a frame check and a next-index state, and
// the refine and done states close the two passes and post the result; busy_o stays
// high throughout. The single result beat appears on result_o for one cycle, marked by
// done_o, and must be taken then because the receiver cannot stall it.
module weighted_feature_match_search #(
  parameter int unsigned FEATURE_DIM = 46
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  wfms_pkg::in_item_t     item_i,
  output logic                   done_o,
  output wfms_pkg::out_item_t    result_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned FrW   = $clog2(wfms_pkg::MaxFrames);
  localparam int unsigned DimW  = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1;
  localparam int unsigned FDepth = wfms_pkg::MaxFrames * FEATURE_DIM;
  localparam int unsigned FAW   = $clog2(FDepth);
  localparam int unsigned CntW  = FrW + 2;
  localparam int unsigned CW    = wfms_pkg::CostW;

  typedef enum logic [3:0] {
    StIdle, StFrame, StRead, StDiff, StMulA, StMulB, StMulC, StMulD, StAcc,
    StNext, StRefine, StDone
  } state_e;

  state_e state_q;
  logic [12:0] frames_q;
  logic [11:0] stride_q;
  logic        done_q;
  wfms_pkg::out_item_t res_q;

  logic        refine_q;
  logic [CntW-1:0] idx_q, hi_q, n_q, str_q;
  logic [11:0] cur_q, span_q;
  logic [DimW-1:0] dim_q;
  logic [CW-1:0] cost_q, best_cost_q;
  logic [11:0] best_idx_q;
  logic        found_q;
  logic [24:0] mag_q;
  logic [32:0] scaled_q;
  logic [63:0] sq_q;
  logic [CW+16:0] term_q;

  logic [23:0] feat_rd, query_rd;
  logic [15:0] wght_rd, inv_rd;

  logic accept;
  assign accept = start_i && !busy_o;

  wfms_pkg::in_item_t it;
  assign it = item_i;
  logic dim_ok, ld;
  assign dim_ok = ({26'd0, it.dim_index} < 32'(FEATURE_DIM));
  assign ld = accept && dim_ok;

  logic [FAW-1:0] f_waddr, f_raddr;
  assign f_waddr = FAW'(({20'd0, it.frame_index} * FEATURE_DIM) + {26'd0, it.dim_index});
  assign f_raddr = FAW'(({{(32-CntW){1'b0}}, idx_q} * FEATURE_DIM) +
                        {{(32-DimW){1'b0}}, dim_q});

  wfms_ram #(.Width(24), .Depth(FDepth)) u_feat (
    .clk_i, .we_i(ld && it.func == wfms_pkg::FuncLoadFeat &&
                  ({20'd0, it.frame_index} < 32'(wfms_pkg::MaxFrames))),
    .waddr_i(f_waddr), .wdata_i(it.load_value), .raddr_i(f_raddr), .rdata_o(feat_rd));
  wfms_ram #(.Width(24), .Depth(FEATURE_DIM)) u_query (
    .clk_i, .we_i(ld && it.func == wfms_pkg::FuncLoadQuery), .waddr_i(it.dim_index[DimW-1:0]),
    .wdata_i(it.load_value), .raddr_i(dim_q), .rdata_o(query_rd));
  wfms_ram #(.Width(16), .Depth(FEATURE_DIM)) u_wght (
    .clk_i, .we_i(ld && it.func == wfms_pkg::FuncLoadWght), .waddr_i(it.dim_index[DimW-1:0]),
    .wdata_i(it.load_value[15:0]), .raddr_i(dim_q), .rdata_o(wght_rd));
  wfms_ram #(.Width(16), .Depth(FEATURE_DIM)) u_inv (
    .clk_i, .we_i(ld && it.func == wfms_pkg::FuncLoadInv), .waddr_i(it.dim_index[DimW-1:0]),
    .wdata_i(it.load_value[15:0]), .raddr_i(dim_q), .rdata_o(inv_rd));

  // Shared multiplier.
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StMulA: begin
        mul_a = {8'd0, mag_q};
        mul_b = {17'd0, inv_rd};
      end
      StMulB: begin
        mul_a = scaled_q;
        mul_b = scaled_q;
      end
      StMulC: begin
        mul_a = {1'b0, sq_q[63:32]};
        mul_b = {17'd0, wght_rd};
      end
      StMulD: begin
        mul_a = {1'b0, sq_q[31:0]};
        mul_b = {17'd0, wght_rd};
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  logic signed [24:0] diff;
  assign diff = {feat_rd[23], feat_rd} - {query_rd[23], query_rd};

  logic [CntW-1:0] idx_gap;
  assign idx_gap = (idx_q >= {2'd0, cur_q}) ? idx_q - {2'd0, cur_q} : {2'd0, cur_q} - idx_q;
  logic excl;
  assign excl = (span_q != 12'd0) && (idx_gap <= {2'd0, span_q});

  logic [CW:0] acc_sum;
  assign acc_sum = {1'b0, cost_q} + ((term_q > {17'd0, wfms_pkg::CostMax}) ?
                   {1'b0, wfms_pkg::CostMax} : {1'b0, term_q[CW-1:0]});

  logic [CntW-1:0] cand_lo, cand_hi, bidx;
  assign bidx    = {2'd0, best_idx_q};
  assign cand_lo = (bidx > str_q) ? bidx - str_q : '0;
  assign cand_hi = (bidx + str_q > n_q - 1'b1) ? n_q - 1'b1 : bidx + str_q;

  logic [CntW-1:0] n_eff;
  assign n_eff = ({{(CntW-13){1'b0}}, frames_q} > CntW'(wfms_pkg::MaxFrames)) ?
                 CntW'(wfms_pkg::MaxFrames) : CntW'(frames_q);

  logic wr;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      frames_q <= 13'd0;
      stride_q <= 12'd1;
      done_q   <= 1'b0;
      refine_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (wr && paddr[2] == wfms_pkg::RegFrames) frames_q <= pwdata[12:0];
      if (wr && paddr[2] == wfms_pkg::RegStride) stride_q <= pwdata[11:0];
      unique case (state_q)
        StIdle: begin
          if (accept && it.func == wfms_pkg::FuncSearch) begin
            cur_q <= it.current_frame;
            span_q <= it.exclude_span;
            n_q <= n_eff;
            str_q <= (stride_q == 12'd0) ? CntW'(1) : CntW'(stride_q);
            best_idx_q <= it.current_frame;
            best_cost_q <= '0;
            found_q <= 1'b0;
            refine_q <= 1'b0;
            idx_q <= '0;
            hi_q <= n_eff - 1'b1;
            state_q <= (n_eff == '0) ? StDone : StFrame;
          end
        end
        StFrame: begin
          if (idx_q > hi_q || (!refine_q && idx_q >= n_q)) begin
            state_q <= refine_q ? StDone : StRefine;
          end else if (excl) begin
            state_q <= StNext;
          end else begin
            dim_q <= '0;
            cost_q <= '0;
            state_q <= StRead;
          end
        end
        StRead: state_q <= StDiff;
        StDiff: begin
          mag_q <= diff[24] ? 25'(-diff) : 25'(diff);
          state_q <= StMulA;
        end
        StMulA: begin
          scaled_q <= 33'((mul_p + 66'd128) >> 8);
          state_q <= StMulB;
        end
        StMulB: begin
          sq_q <= mul_p[63:0];
          state_q <= StMulC;
        end
        StMulC: begin
          term_q <= (CW+17)'({mul_p[48:0], 32'd0} >> 20);
          state_q <= StMulD;
        end
        StMulD: begin
          term_q <= term_q + (CW+17)'(mul_p[47:0] >> 20);
          state_q <= StAcc;
        end
        StAcc: begin
          cost_q <= acc_sum[CW] ? wfms_pkg::CostMax : acc_sum[CW-1:0];
          if ({{(32-DimW){1'b0}}, dim_q} == 32'(FEATURE_DIM - 1)) begin
            state_q <= StNext;
            if (!found_q || (acc_sum[CW] ? wfms_pkg::CostMax : acc_sum[CW-1:0]) < best_cost_q)
            begin
              found_q <= 1'b1;
              best_cost_q <= acc_sum[CW] ? wfms_pkg::CostMax : acc_sum[CW-1:0];
              best_idx_q <= idx_q[11:0];
            end
          end else begin
            dim_q <= dim_q + 1'b1;
            state_q <= StRead;
          end
        end
        StNext: begin
          idx_q <= refine_q ? idx_q + 1'b1 : idx_q + str_q;
          state_q <= StFrame;
        end
        StRefine: begin
          refine_q <= 1'b1;
          idx_q <= cand_lo;
          hi_q <= cand_hi;
          state_q <= (bidx > n_q - 1'b1 + str_q) ? StDone : StFrame;
        end
        StDone: begin
          done_q <= 1'b1;
          res_q.best_index <= best_idx_q;
          res_q.best_cost <= found_q ? best_cost_q : '0;
          res_q.found <= found_q;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o   = (state_q != StIdle);
  assign done_o   = done_q;
  assign result_o = res_q;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == wfms_pkg::RegFrames) ? {19'd0, frames_q} : {20'd0, stride_q};

endmodule

### hdl/wfms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wfms_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### tb/tb_weighted_feature_match_search.sv
// Self-checking testbench for the weighted feature match search block.
module tb_weighted_feature_match_search;

  localparam int NumFrames = 4096;
  localparam int NumDims = 46;
  localparam int LoadedFrames = 2;
  localparam int IdleLimit = 300000;

  typedef struct {
    bit                  is_reg;
    wfms_pkg::in_item_t  item;
    logic [2:0]          addr;
    logic [31:0]         data;
    bit                  typed;
    wfms_pkg::out_item_t fixed;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  wfms_pkg::in_item_t  item_i;
  logic                done_o;
  wfms_pkg::out_item_t result_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int          feat_mem [NumFrames*NumDims];
  int          query_vec [NumDims];
  int unsigned weight_vec [NumDims];
  int unsigned invdev_vec [NumDims];
  int unsigned frames_reg;
  int unsigned stride_reg;

  wfms_pkg::out_item_t match_q [$];
  bit                  fixed_valid;
  wfms_pkg::out_item_t fixed_match;
  int                  errors;
  int                  idle_cycles;
  stim_row_t           rows [$];

  weighted_feature_match_search dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned frame_score(int f);
    longint unsigned acc;
    longint unsigned mag;
    longint unsigned scaled;
    longint unsigned sq;
    longint unsigned w;
    longint unsigned term;
    longint diff;
    acc = 0;
    for (int d = 0; d < NumDims; d++) begin
      diff = longint'(feat_mem[f*NumDims+d]) - longint'(query_vec[d]);
      mag = (diff < 0) ? -diff : diff;
      scaled = (mag * invdev_vec[d] + 128) >> 8;
      sq = scaled * scaled;
      w = weight_vec[d];
      term = w * (sq >> 20) + ((w * (sq & 64'hFFFFF)) >> 20);
      if (term > wfms_pkg::CostMax) term = wfms_pkg::CostMax;
      acc = acc + term;
      if (acc > wfms_pkg::CostMax) acc = wfms_pkg::CostMax;
    end
    return acc;
  endfunction

  function automatic bit skipped(int i, int cur, int span);
    int offset;
    offset = (i > cur) ? i - cur : cur - i;
    return span > 0 && offset <= span;
  endfunction

  // Updates the stores for loads and returns 1 with the match for a search.
  function automatic bit apply_item(wfms_pkg::in_item_t it, output wfms_pkg::out_item_t m);
    int n, step, lo, hi, best_idx, cur, span, v;
    longint unsigned best, c;
    bit fnd;
    v = int'(it.load_value);
    m = '0;
    if (it.func <= wfms_pkg::FuncLoadInv) begin
      if (it.dim_index < NumDims) begin
        case (it.func)
          wfms_pkg::FuncLoadFeat: feat_mem[it.frame_index*NumDims+it.dim_index] = v;
          wfms_pkg::FuncLoadQuery: query_vec[it.dim_index] = v;
          wfms_pkg::FuncLoadWght: weight_vec[it.dim_index] = v & 32'hFFFF;
          default: invdev_vec[it.dim_index] = v & 32'hFFFF;
        endcase
      end
      return 1'b0;
    end
    if (it.func != wfms_pkg::FuncSearch) return 1'b0;
    n = (frames_reg > NumFrames) ? NumFrames : frames_reg;
    step = (stride_reg == 0) ? 1 : stride_reg;
    cur = it.current_frame;
    span = it.exclude_span;
    best_idx = cur;
    best = 0;
    fnd = 1'b0;
    if (n > 0) begin
      for (int i = 0; i < n; i += step) begin
        if (skipped(i, cur, span)) continue;
        c = frame_score(i);
        if (!fnd || c < best) begin
          fnd = 1'b1;
          best = c;
          best_idx = i;
        end
      end
      lo = (best_idx - step < 0) ? 0 : best_idx - step;
      hi = (best_idx + step > n - 1) ? n - 1 : best_idx + step;
      for (int i = lo; i <= hi; i++) begin
        if (skipped(i, cur, span)) continue;
        c = frame_score(i);
        if (!fnd || c < best) begin
          fnd = 1'b1;
          best = c;
          best_idx = i;
        end
      end
    end
    m.best_index = best_idx[11:0];
    m.best_cost = fnd ? best[wfms_pkg::CostW-1:0] : '0;
    m.found = fnd;
    return 1'b1;
  endfunction

  function automatic wfms_pkg::in_item_t mk(logic [2:0] func, int frame, int dim, int val,
                                            int cur, int span);
    wfms_pkg::in_item_t it;
    it.func = func;
    it.frame_index = frame[11:0];
    it.dim_index = dim[5:0];
    it.load_value = val[23:0];
    it.current_frame = cur[11:0];
    it.exclude_span = span[11:0];
    return it;
  endfunction

  always @(posedge clk_i) begin
    wfms_pkg::out_item_t m;
    wfms_pkg::out_item_t e;
    if (rst_ni && start_i && !busy_o) begin
      if (apply_item(item_i, m)) match_q.push_back(fixed_valid ? fixed_match : m);
    end
    if (rst_ni && done_o) begin
      if (match_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result_o);
        errors++;
      end else begin
        e = match_q.pop_front();
        if (result_o.best_index !== e.best_index) begin
          $display("%0t: best_index expected %0d actual %0d", $time, e.best_index,
                   result_o.best_index);
          errors++;
        end
        if (result_o.best_cost !== e.best_cost) begin
          $display("%0t: best_cost expected %0h actual %0h", $time, e.best_cost,
                   result_o.best_cost);
          errors++;
        end
        if (result_o.found !== e.found) begin
          $display("%0t: found expected %0b actual %0b", $time, e.found, result_o.found);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(wfms_pkg::in_item_t it, bit typed, wfms_pkg::out_item_t fixed);
    int gap;
    start_i <= 1'b1;
    item_i <= it;
    fixed_valid <= typed;
    fixed_match <= fixed;
    do @(posedge clk_i); while (busy_o);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (match_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    settle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'(4 * wfms_pkg::RegFrames)) frames_reg = data & 32'h1FFF;
    else stride_reg = data & 32'hFFF;
  endtask

  function automatic int rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return int'($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
    return int'($urandom_range(0, 8192)) - 4096;
  endfunction

  initial begin
    wfms_pkg::out_item_t none;
    wfms_pkg::in_item_t it;
    int sel;
    none = '0;
    errors = 0;
    idle_cycles = 0;
    frames_reg = 0;
    stride_reg = 1;
    start_i = 1'b0;
    item_i = '0;
    fixed_valid = 1'b0;
    fixed_match = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every searched entry so that no search reads an unwritten word.
    for (int d = 0; d < NumDims; d++) begin
      send(mk(wfms_pkg::FuncLoadQuery, 0, d, rand_value(), 0, 0), 1'b0, none);
      send(mk(wfms_pkg::FuncLoadWght, 0, d, $urandom_range(0, 16'hFFFF), 0, 0), 1'b0, none);
      send(mk(wfms_pkg::FuncLoadInv, 0, d, $urandom_range(0, 16'h3FF), 0, 0), 1'b0, none);
      for (int f = 0; f < LoadedFrames; f++)
        send(mk(wfms_pkg::FuncLoadFeat, f, d, rand_value(), 0, 0), 1'b0, none);
    end
    settle();

    rows.push_back('{0, mk(wfms_pkg::FuncSearch, 0, 0, 0, 4095, 0), 0, 0, 1,
                     '{12'd4095, '0, 1'b0}});
    rows.push_back('{0, mk(wfms_pkg::FuncSearch, 0, 0, 0, 0, 4095), 0, 0, 1,
                     '{12'd0, '0, 1'b0}});
    rows.push_back('{0, mk(3'd5, 0, 0, 0, 0, 0), 0, 0, 0, none});
    rows.push_back('{0, mk(3'd7, 4095, 63, -1, 4095, 4095), 0, 0, 0, none});
    rows.push_back('{0, mk(wfms_pkg::FuncLoadQuery, 0, 63, -8388608, 0, 0), 0, 0, 0, none});
    rows.push_back('{0, mk(wfms_pkg::FuncLoadFeat, 4095, 45, 8388607, 0, 0), 0, 0, 0, none});
    rows.push_back('{1, '0, 3'(4 * wfms_pkg::RegFrames), 32'd1, 0, none});
    rows.push_back('{0, mk(wfms_pkg::FuncSearch, 0, 0, 0, 0, 0), 0, 0, 0, none});
    rows.push_back('{0, mk(wfms_pkg::FuncSearch, 0, 0, 0, 0, 1), 0, 0, 1,
                     '{12'd0, '0, 1'b0}});
    rows.push_back('{0, mk(wfms_pkg::FuncLoadFeat, 0, 0, 8388607, 0, 0), 0, 0, 0, none});
    rows.push_back('{0, mk(wfms_pkg::FuncLoadQuery, 0, 0, -8388608, 0, 0), 0, 0, 0, none});
    rows.push_back('{0, mk(wfms_pkg::FuncLoadWght, 0, 0, -1, 0, 0), 0, 0, 0, none});
    rows.push_back('{0, mk(wfms_pkg::FuncLoadInv, 0, 0, -1, 0, 0), 0, 0, 0, none});
    rows.push_back('{0, mk(wfms_pkg::FuncSearch, 0, 0, 0, 4095, 0), 0, 0, 1,
                     '{12'd0, wfms_pkg::CostMax, 1'b1}});
    rows.push_back('{0, mk(wfms_pkg::FuncLoadWght, 0, 0, 0, 0, 0), 0, 0, 0, none});
    rows.push_back('{1, '0, 3'(4 * wfms_pkg::RegFrames), 32'(LoadedFrames), 0, none});
    rows.push_back('{1, '0, 3'(4 * wfms_pkg::RegStride), 32'd4095, 0, none});
    rows.push_back('{0, mk(wfms_pkg::FuncSearch, 0, 0, 0, 12, 3), 0, 0, 0, none});
    rows.push_back('{1, '0, 3'(4 * wfms_pkg::RegStride), 32'd0, 0, none});
    rows.push_back('{0, mk(wfms_pkg::FuncSearch, 0, 0, 0, 5, 2), 0, 0, 0, none});
    rows.push_back('{1, '0, 3'(4 * wfms_pkg::RegFrames), 32'd8191, 0, none});
    rows.push_back('{0, mk(wfms_pkg::FuncSearch, 0, 0, 0, 4095, 4095), 0, 0, 1,
                     '{12'd4095, '0, 1'b0}});
    rows.push_back('{1, '0, 3'(4 * wfms_pkg::RegFrames), 32'd4096, 0, none});
    rows.push_back('{0, mk(wfms_pkg::FuncSearch, 0, 0, 0, 4095, 4095), 0, 0, 1,
                     '{12'd4095, '0, 1'b0}});

    foreach (rows[i]) begin
      if (rows[i].is_reg) write_reg(rows[i].addr, rows[i].data);
      else send(rows[i].item, rows[i].typed, rows[i].fixed);
    end

    for (int g = 0; g < 5; g++) begin
      write_reg(3'(4 * wfms_pkg::RegFrames),
                (g == 0) ? 32'd1 : $urandom_range(1, LoadedFrames));
      write_reg(3'(4 * wfms_pkg::RegStride), ($urandom_range(0, 5) == 0) ?
                $urandom_range(0, 4095) : $urandom_range(0, 6));
      for (int k = 0; k < 10; k++) begin
        sel = $urandom_range(0, 19);
        if (sel < 7) begin
          it = mk(wfms_pkg::FuncSearch, $urandom_range(0, 4095), $urandom_range(0, 63),
                  rand_value(),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) :
                  $urandom_range(0, LoadedFrames + 4),
                  ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 4));
        end else if (sel < 18) begin
          it = mk(3'($urandom_range(0, 3)),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) :
                  $urandom_range(0, LoadedFrames - 1),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(46, 63) :
                  $urandom_range(0, 45),
                  rand_value(), $urandom_range(0, 4095), $urandom_range(0, 4095));
          if (it.func == wfms_pkg::FuncLoadInv && $urandom_range(0, 3) != 0)
            it.load_value = 24'($urandom_range(0, 16'h3FF));
        end else begin
          it = mk(3'($urandom_range(5, 7)), $urandom_range(0, 4095), $urandom_range(0, 63),
                  rand_value(), $urandom_range(0, 4095), $urandom_range(0, 4095));
        end
        send(it, 1'b0, none);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
